/* design/pva_pkg.sv */
// pva_pkg: shared types and constants of the polyphonic voice allocator
// no dependencies
package pva_pkg;

    localparam int VOICES = 16;
    localparam int IDX_W  = $clog2(VOICES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int STAMP_W = 32;

    localparam logic [1:0] MODE_ON      = 2'd0;
    localparam logic [1:0] MODE_OFF     = 2'd1;
    localparam logic [1:0] MODE_RETRIG  = 2'd2;
    localparam logic [1:0] MODE_ALL_OFF = 2'd3;

    localparam logic [1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [1:0] CFG_STEAL   = 2'd1;
    localparam logic [1:0] CFG_RECYCLE = 2'd2;

    localparam logic [1:0] STEAL_OLDEST = 2'd1;
    localparam logic [1:0] STEAL_NEWEST = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  key;
        logic [23:0] pitch;
        logic [15:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  voice;
        logic        gate;
        logic        retrigger;
        logic [6:0]  key_out;
        logic [23:0] pitch_out;
        logic [15:0] velocity_out;
        logic        hit;
        logic        last;
    } out_item_t;

    // one entry of the main voice memory
    typedef struct packed {
        logic [6:0]         key;
        logic [23:0]        pitch;
        logic [15:0]        velocity;
        logic [STAMP_W-1:0] on_stamp;
    } voice_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* design/pva_ram.sv */
// pva_ram: generic single write port, single read port ram with registered read
// no dependencies
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/poly_voice_allocator_core.sv */
// poly_voice_allocator_core: top level of the polyphonic voice allocator
// depends on pva_pkg and pva_ram
//
// Voice allocator for a polyphonic synth. Each event item (note on, note off,
// retrigger, all notes off) is taken while the block is idle. The block then
// scans the voice table, one voice read per cycle from the voice memories
// unless a match stalls on a full result side, and sends one result item per
// voice it touched (or one item with hit = 0 when it touched none). The final
// result item is marked with last. The block takes no new item until it is
// through with the last one. The scan covers active_voices voices, clipped to
// 16, for note on and retrigger, and all 16 voices for note off and all off.
// Stamps and keys live in two rams with registered read. Gate and used bits
// sit in flops so reset clears them at once, and no clearing pass is needed.
// Configuration writes are taken any time but are meant for idle periods.
module poly_voice_allocator_core
    import pva_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [4:0]  cfg_data
);

    // configuration
    logic [4:0] active_reg;
    logic [1:0] steal_reg;
    logic       recycle_reg;

    state_t state_reg, state_next;
    in_item_t item_reg;

    // scan pipeline: read index and the voice whose data is on the ram output
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    logic [VOICES-1:0] gate_reg, gate_next;
    logic [VOICES-1:0] used_reg, used_next;
    logic [STAMP_W-1:0] on_cnt_reg, on_cnt_next;
    logic [STAMP_W-1:0] rel_cnt_reg, rel_cnt_next;

    // note-on selection trackers
    logic               first_reg, first_next;
    logic               have_reg, have_next;
    logic [STAMP_W-1:0] min_rel_reg, min_rel_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [IDX_W-1:0]   old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic [IDX_W-1:0]   new_idx_reg, new_idx_next;
    logic [STAMP_W-1:0] new_stamp_reg, new_stamp_next;

    // held result: sent once the next match or the end of scan tells last
    logic      pend_vld_reg, pend_vld_next;
    out_item_t pend_reg, pend_next;

    logic      m_vld_reg, m_vld_next;
    out_item_t m_item_reg, m_item_next;

    // memories
    logic               a_we, b_we, rd_en;
    logic [IDX_W-1:0]   a_waddr, b_waddr, raddr;
    voice_word_t        a_wdata, a_q;
    logic [STAMP_W-1:0] b_wdata, b_q;

    logic [CNT_W-1:0] n_eff, scan_lim;
    logic             more, match, hit_v, stall, out_free;
    logic             steal_ok, do_on;
    logic [IDX_W-1:0] fpick;
    out_item_t        miss_item, cur_item;

    pva_ram #(.WIDTH($bits(voice_word_t)), .DEPTH(VOICES)) u_voice_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (a_q)
    );

    pva_ram #(.WIDTH(STAMP_W), .DEPTH(VOICES)) u_release_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (b_q)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_vld_reg;
    assign m_item  = m_item_reg;
    assign out_free = !m_vld_reg || m_ready;

    // active count clipped to the table size
    assign n_eff = (active_reg > CNT_W'(VOICES)) ? CNT_W'(VOICES) : active_reg;
    assign scan_lim = (item_reg.mode == MODE_OFF || item_reg.mode == MODE_ALL_OFF)
                      ? CNT_W'(VOICES) : n_eff;
    assign more = rd_idx_reg < scan_lim;
    assign raddr = rd_idx_reg[IDX_W-1:0];

    always_comb begin
        case (item_reg.mode)
            MODE_OFF:     match = gate_reg[chk_idx_reg] && (a_q.key == item_reg.key);
            MODE_ALL_OFF: match = gate_reg[chk_idx_reg];
            MODE_RETRIG:  match = used_reg[chk_idx_reg] && (a_q.key == item_reg.key);
            default:      match = 1'b0;
        endcase
    end

    assign hit_v = (state_reg == ST_SCAN) && chk_vld_reg && match;
    // a second match cannot move the held result while the output is full
    assign stall = hit_v && pend_vld_reg && !out_free;

    assign steal_ok = (n_eff != '0) && (steal_reg == STEAL_OLDEST || steal_reg == STEAL_NEWEST);
    assign do_on = have_reg || steal_ok;
    assign fpick = have_reg ? pick_reg : ((steal_reg == STEAL_OLDEST) ? old_idx_reg : new_idx_reg);

    always_comb begin
        miss_item = '0;
        miss_item.last = 1'b1;
    end

    // result for the voice under check
    always_comb begin
        cur_item = '0;
        cur_item.voice = chk_idx_reg;
        cur_item.pitch_out = a_q.pitch;
        cur_item.velocity_out = a_q.velocity;
        cur_item.hit = 1'b1;
        if (item_reg.mode == MODE_RETRIG) begin
            cur_item.gate = gate_reg[chk_idx_reg];
            cur_item.retrigger = 1'b1;
            cur_item.key_out = gate_reg[chk_idx_reg] ? a_q.key : '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!more && !chk_vld_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        rd_idx_next = rd_idx_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        gate_next = gate_reg;
        used_next = used_reg;
        on_cnt_next = on_cnt_reg;
        rel_cnt_next = rel_cnt_reg;
        first_next = first_reg;
        have_next = have_reg;
        min_rel_next = min_rel_reg;
        pick_next = pick_reg;
        old_idx_next = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        new_idx_next = new_idx_reg;
        new_stamp_next = new_stamp_reg;
        pend_vld_next = pend_vld_reg;
        pend_next = pend_reg;
        m_vld_next = m_vld_reg && !m_ready;
        m_item_next = m_item_reg;
        rd_en = 1'b0;
        a_we = 1'b0;
        a_waddr = chk_idx_reg;
        a_wdata = a_q;
        b_we = 1'b0;
        b_waddr = chk_idx_reg;
        b_wdata = rel_cnt_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                rd_idx_next = '0;
                chk_vld_next = 1'b0;
                first_next = 1'b0;
                have_next = 1'b0;
                pend_vld_next = 1'b0;
            end
            ST_SCAN: begin
                if (!stall) begin
                    rd_en = more;
                    chk_vld_next = more;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    if (more) begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (chk_vld_reg && item_reg.mode == MODE_ON && !first_reg) begin
                    if (!gate_reg[chk_idx_reg]) begin
                        if (!used_reg[chk_idx_reg] || recycle_reg) begin
                            pick_next = chk_idx_reg;
                            first_next = 1'b1;
                            have_next = 1'b1;
                        end else if (!have_reg || b_q < min_rel_reg) begin
                            pick_next = chk_idx_reg;
                            min_rel_next = b_q;
                            have_next = 1'b1;
                        end
                    end
                    if (chk_idx_reg == '0 || a_q.on_stamp < old_stamp_reg) begin
                        old_idx_next = chk_idx_reg;
                        old_stamp_next = a_q.on_stamp;
                    end
                    if (chk_idx_reg == '0 || a_q.on_stamp > new_stamp_reg) begin
                        new_idx_next = chk_idx_reg;
                        new_stamp_next = a_q.on_stamp;
                    end
                end
                if (hit_v && !stall) begin
                    if (item_reg.mode == MODE_RETRIG) begin
                        on_cnt_next = on_cnt_reg + 1'b1;
                        a_we = 1'b1;
                        a_wdata.on_stamp = on_cnt_reg + 1'b1;
                    end else begin
                        rel_cnt_next = rel_cnt_reg + 1'b1;
                        b_we = 1'b1;
                        gate_next[chk_idx_reg] = 1'b0;
                    end
                    if (pend_vld_reg) begin
                        m_vld_next = 1'b1;
                        m_item_next = pend_reg;
                    end
                    pend_vld_next = 1'b1;
                    pend_next = cur_item;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_vld_next = 1'b1;
                    m_item_next = miss_item;
                    if (item_reg.mode == MODE_ON) begin
                        if (do_on) begin
                            on_cnt_next = on_cnt_reg + 1'b1;
                            a_we = 1'b1;
                            a_waddr = fpick;
                            a_wdata.key = item_reg.key;
                            a_wdata.pitch = item_reg.pitch;
                            a_wdata.velocity = item_reg.velocity;
                            a_wdata.on_stamp = on_cnt_reg + 1'b1;
                            gate_next[fpick] = 1'b1;
                            used_next[fpick] = 1'b1;
                            m_item_next.voice = fpick;
                            m_item_next.gate = 1'b1;
                            m_item_next.key_out = item_reg.key;
                            m_item_next.pitch_out = item_reg.pitch;
                            m_item_next.velocity_out = item_reg.velocity;
                            m_item_next.hit = 1'b1;
                        end
                    end else if (pend_vld_reg) begin
                        m_item_next = pend_reg;
                        m_item_next.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            active_reg <= 5'd16;
            steal_reg <= '0;
            recycle_reg <= 1'b0;
            rd_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            gate_reg <= '0;
            used_reg <= '0;
            on_cnt_reg <= '0;
            rel_cnt_reg <= '0;
            first_reg <= 1'b0;
            have_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_ACTIVE:  active_reg <= cfg_data;
                    CFG_STEAL:   steal_reg <= cfg_data[1:0];
                    CFG_RECYCLE: recycle_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            rd_idx_reg <= rd_idx_next;
            chk_vld_reg <= chk_vld_next;
            gate_reg <= gate_next;
            used_reg <= used_next;
            on_cnt_reg <= on_cnt_next;
            rel_cnt_reg <= rel_cnt_next;
            first_reg <= first_next;
            have_reg <= have_next;
            pend_vld_reg <= pend_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        chk_idx_reg <= chk_idx_next;
        min_rel_reg <= min_rel_next;
        pick_reg <= pick_next;
        old_idx_reg <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
        new_idx_reg <= new_idx_next;
        new_stamp_reg <= new_stamp_next;
        pend_reg <= pend_next;
        m_item_reg <= m_item_next;
    end

    // a sounding voice has always been used
    a_gate_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (gate_reg & ~used_reg) == '0)
        else $error("gated voice not marked used");

    // no result is held back while the block waits for an item
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("held result left over in idle");

    // an accepted item always starts a scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start a scan");

    // the final result of an item carries last as control goes back to idle
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_valid && m_item.last))
        else $error("final result missing last");

endmodule
